// ----- rtl/clcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and constants of the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int unsigned SLOTS      = 6;   // most strobes one item can cause
  localparam int unsigned INIT_COUNT = 8;   // instructions in the init list
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned STEP_W     = $clog2(INIT_COUNT);

  localparam logic [15:0] INIT_POWERUP_US = 16'd40000;
  localparam logic [15:0] INIT_MID_US     = 16'd2000;
  localparam logic [15:0] INIT_SHORT_US   = 16'd30;

  typedef enum logic [2:0] {
    CMD_WR_INSTR  = 3'd0,
    CMD_WR_DATA   = 3'd1,
    CMD_BACKLIGHT = 3'd2,
    CMD_INIT      = 3'd3,
    CMD_STATUS    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_INSTR_SKIP = 2'd0,
    CFG_DATA_SKIP  = 2'd1,
    CFG_LINE_MODE  = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] LM_TWO_LINES   = 2'd1;
  localparam logic [1:0] LM_THREE_LINES = 2'd2;

  // one enable strobe
  typedef struct packed {
    logic [15:0] wait_us;
    logic        sample_busy;
    logic        drive_data;
    logic [3:0]  nibble;
    logic        read_not_write;
    logic        reg_select;
  } strobe_t;

  // all results of one item
  typedef struct packed {
    logic [SLOT_W-1:0]       cnt;        // number of results, 1..SLOTS
    logic                    is_status;  // single status-only result
    logic                    rej;
    logic                    bl;
    strobe_t [SLOTS-1:0]     slots;
  } bundle_t;

  typedef struct packed {
    logic       present;
    logic [7:0] code;
  } init_ent_t;

  function automatic strobe_t poll_strobe(input logic first);
    strobe_t s;
    s = '0;
    s.read_not_write = 1'b1;
    s.sample_busy    = first;
    return s;
  endfunction

  function automatic strobe_t write_strobe(input logic rs, input logic [3:0] nib,
                                           input logic [15:0] wt);
    strobe_t s;
    s = '0;
    s.reg_select = rs;
    s.nibble     = nib;
    s.drive_data = 1'b1;
    s.wait_us    = wt;
    return s;
  endfunction

  function automatic init_ent_t init_entry(input logic [STEP_W-1:0] step,
                                           input logic [1:0] line_mode);
    init_ent_t e;
    e.present = 1'b1;
    e.code    = 8'h00;
    unique case (step)
      3'd0: e.code = 8'h29;
      3'd1: begin
        // bias instruction, left out for unknown modes
        if (line_mode == LM_TWO_LINES) e.code = 8'h1C;
        else if (line_mode == LM_THREE_LINES) e.code = 8'h1D;
        else e.present = 1'b0;
      end
      3'd2: e.code = 8'h50;
      3'd3: e.code = 8'h6C;
      3'd4: e.code = 8'h7C;
      3'd5: e.code = 8'h0C;
      3'd6: e.code = 8'h01;
      3'd7: e.code = 8'h06;
      default: e.present = 1'b0;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/clcd_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_engine
// Decodes one request, updates the transfer state and builds the list of
// strobes it causes.
// ----------------------------------------------------------------------------
module clcd_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 fire_i,
  input  logic [2:0]           cmd_i,
  input  logic [7:0]           val_i,
  input  logic                 busy_i,
  output clcd_pkg::bundle_t    bundle_o
);
  import clcd_pkg::*;

  logic [7:0]        iskip_q, dskip_q;
  logic [1:0]        line_mode_q;

  logic              pend_q, pend_d;
  logic [7:0]        pend_byte_q, pend_byte_d;
  logic              pend_data_q, pend_data_d;
  logic [STEP_W-1:0] init_step_q, init_step_d;
  logic              init_act_q, init_act_d;
  logic              bl_q, bl_d;

  logic [STEP_W:0]     start;
  logic [INIT_COUNT-1:0] ok;
  logic [STEP_W-1:0]   found_step;
  logic                found;
  init_ent_t           found_ent;
  logic                reject;
  logic [7:0]          skip;
  bundle_t             bnd;

  // next init instruction at or after start that is neither absent nor skipped
  assign start = (cmd_i == CMD_INIT) ? '0 : ({1'b0, init_step_q} + 1'b1);

  always_comb begin
    init_ent_t e;
    for (int s = 0; s < INIT_COUNT; s++) begin
      e     = init_entry(STEP_W'(s), line_mode_q);
      ok[s] = e.present && (e.code != iskip_q) && ((STEP_W+1)'(s) >= start);
    end
  end

  always_comb begin
    found_step = '0;
    for (int s = INIT_COUNT - 1; s >= 0; s--) begin
      if (ok[s]) found_step = STEP_W'(s);
    end
  end

  assign found     = |ok;
  assign found_ent = init_entry(found_step, line_mode_q);
  assign reject    = (cmd_i > CMD_STATUS) || ((cmd_i != CMD_STATUS) && pend_q) ||
                     ((cmd_i == CMD_STATUS) && !pend_q);
  assign skip      = (cmd_i == CMD_WR_DATA) ? dskip_q : iskip_q;

  always_comb begin
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    pend_data_d = pend_data_q;
    init_step_d = init_step_q;
    init_act_d  = init_act_q;
    bl_d        = bl_q;
    bnd           = '0;
    bnd.cnt       = SLOT_W'(1);
    bnd.is_status = 1'b1;

    if (reject) begin
      bnd.rej = 1'b1;
    end else begin
      unique case (cmd_e'(cmd_i))
        CMD_WR_INSTR, CMD_WR_DATA: begin
          if (val_i != skip) begin
            pend_d        = 1'b1;
            pend_byte_d   = val_i;
            pend_data_d   = cmd_i[0];
            bnd.is_status = 1'b0;
            bnd.cnt       = SLOT_W'(2);
            bnd.slots[0]  = poll_strobe(1'b1);
            bnd.slots[1]  = poll_strobe(1'b0);
          end
        end
        CMD_BACKLIGHT: bl_d = |val_i;
        CMD_INIT: begin
          bnd.is_status = 1'b0;
          bnd.slots[0]  = write_strobe(1'b0, 4'h3, INIT_POWERUP_US);
          bnd.slots[1]  = write_strobe(1'b0, 4'h3, INIT_MID_US);
          bnd.slots[2]  = write_strobe(1'b0, 4'h3, INIT_SHORT_US);
          bnd.slots[3]  = write_strobe(1'b0, 4'h2, INIT_SHORT_US);
          if (found) begin
            init_act_d   = 1'b1;
            init_step_d  = found_step;
            pend_d       = 1'b1;
            pend_byte_d  = found_ent.code;
            pend_data_d  = 1'b0;
            bnd.cnt      = SLOT_W'(6);
            bnd.slots[4] = poll_strobe(1'b1);
            bnd.slots[5] = poll_strobe(1'b0);
          end else begin
            init_act_d  = 1'b0;
            init_step_d = '0;
            bnd.cnt     = SLOT_W'(4);
          end
        end
        CMD_STATUS: begin
          bnd.is_status = 1'b0;
          bnd.cnt       = SLOT_W'(2);
          if (busy_i) begin
            bnd.slots[0] = poll_strobe(1'b1);
            bnd.slots[1] = poll_strobe(1'b0);
          end else begin
            pend_d       = 1'b0;
            bnd.slots[0] = write_strobe(pend_data_q, pend_byte_q[7:4], 16'd0);
            bnd.slots[1] = write_strobe(pend_data_q, pend_byte_q[3:0], 16'd0);
            if (init_act_q) begin
              if (found) begin
                init_step_d  = found_step;
                pend_d       = 1'b1;
                pend_byte_d  = found_ent.code;
                pend_data_d  = 1'b0;
                bnd.cnt      = SLOT_W'(4);
                bnd.slots[2] = poll_strobe(1'b1);
                bnd.slots[3] = poll_strobe(1'b0);
              end else begin
                init_act_d  = 1'b0;
                init_step_d = '0;
              end
            end
          end
        end
        default: bnd.rej = 1'b1;
      endcase
    end
    bnd.bl = bl_d;
  end

  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iskip_q     <= 8'hFF;
      dskip_q     <= 8'hFF;
      line_mode_q <= LM_TWO_LINES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INSTR_SKIP: iskip_q     <= cfg_wdata_i;
        CFG_DATA_SKIP:  dskip_q     <= cfg_wdata_i;
        CFG_LINE_MODE:  line_mode_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      pend_byte_q <= 8'h00;
      pend_data_q <= 1'b0;
      init_step_q <= '0;
      init_act_q  <= 1'b0;
      bl_q        <= 1'b0;
    end else if (fire_i) begin
      pend_q      <= pend_d;
      pend_byte_q <= pend_byte_d;
      pend_data_q <= pend_data_d;
      init_step_q <= init_step_d;
      init_act_q  <= init_act_d;
      bl_q        <= bl_d;
    end
  end

endmodule

// ----- rtl/clcd_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_outq
// Two-entry queue of result lists; sends the strobes of the head list one
// per cycle on the result stream while the receiver is ready.
// ----------------------------------------------------------------------------
module clcd_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_rdy_o,
  input  clcd_pkg::bundle_t bundle_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // reg_select, read_not_write, nibble,
                                            // drive_data, sample_busy, wait_us,
                                            // backlight_on, zero fill
  output logic [1:0]        m_axis_tuser,   // strobe_valid, rejected
  output logic              m_axis_tlast
);
  import clcd_pkg::*;

  bundle_t           bnd_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic [SLOT_W-1:0] idx_q;
  bundle_t           head;
  strobe_t           slot;
  logic              last, beat, pop, push;

  assign head  = bnd_q[rd_ptr_q];
  assign slot  = head.slots[idx_q];
  assign last  = (idx_q == head.cnt - 1'b1);
  assign beat  = m_axis_tvalid && m_axis_tready;
  assign pop   = beat && last;

  assign push_rdy_o = (cnt_q != 2'd2) || pop;
  assign push       = push_i && push_rdy_o;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {7'd0, head.bl, slot.wait_us, slot.sample_busy, slot.drive_data,
                          slot.nibble, slot.read_not_write, slot.reg_select};
  assign m_axis_tuser  = {head.rej, !head.is_status};
  assign m_axis_tlast  = last;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) bnd_q[wr_ptr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      idx_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        idx_q    <= '0;
      end else if (beat) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/char_lcd_4bit_interface_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_top
// Character LCD controller front end, 4-bit bus mode.
// ----------------------------------------------------------------------------
// Request stream (s_axis): cmd in tuser, value and busy_sample in tdata.
// Write requests poll busy with two read strobes; the host answers with a
// status item carrying the sampled busy bit, then the byte goes out as two
// nibble strobes. Init sends four raw nibbles and the fixed instruction list.
// Result stream (m_axis): one item per strobe or one status-only item;
// tlast closes the run of results caused by one request.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i.
// A request passes the input register, then the result-list queue, before its
// first result is offered.
// One request is accepted per cycle while the two-entry list queue has room;
// a request causing n results holds the result port until all n are taken, so
// the sustained rate follows the results.
// Reset: registers go to their defaults, no transfer pending, backlight off.
// A stalled receiver fills the queue and then deasserts s_axis_tready.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // value, busy_sample, zero fill
  input  logic [2:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // reg_select, read_not_write, nibble, drive_data,
                                      // sample_busy, wait_us, backlight_on, zero fill
  output logic [1:0]  m_axis_tuser,   // strobe_valid, rejected
  output logic        m_axis_tlast
);
  import clcd_pkg::*;

  logic       in_vld_q;
  logic [2:0] in_cmd_q;
  logic [7:0] in_val_q;
  logic       in_busy_q;
  logic       push_rdy, fire;
  bundle_t    bnd;

  assign fire          = in_vld_q && push_rdy;
  assign s_axis_tready = !in_vld_q || push_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_val_q  <= s_axis_tdata[7:0];
      in_busy_q <= s_axis_tdata[8];
    end
  end

  clcd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .cmd_i       (in_cmd_q),
    .val_i       (in_val_q),
    .busy_i      (in_busy_q),
    .bundle_o    (bnd)
  );

  clcd_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (in_vld_q),
    .push_rdy_o    (push_rdy),
    .bundle_i      (bnd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- sim/char_lcd_4bit_interface_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_top_test
// Self-checking bench for the 4-bit character LCD interface. A directed table
// covers rejects, skipped bytes, backlight, busy polling and one full init.
// Random runs follow under several register settings. Both stream sides
// stall at random. Every result item is checked against an in-bench model of
// the strobe sequence.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_top_test;
  import clcd_pkg::*;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          RAND_PER_PHASE  = 48;
  localparam int          HOLD_AT         = 90;   // accepted items before the long stall
  localparam int          LONG_HOLD       = 40;
  localparam logic [2:0]  CMD_UNDEF_FIRST = 3'd5;
  localparam logic [2:0]  CMD_UNDEF_LAST  = 3'd7;

  typedef struct packed {
    logic        rs;
    logic        rnw;
    logic [3:0]  nib;
    logic        drv;
    logic        sb;
    logic [15:0] wait_us;
    logic        bl;
    logic        strobe;
    logic        rej;
    logic        last;
  } lcd_res_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
    logic       busy;
    logic       typed;
    lcd_res_t   want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // value, busy_sample, zero fill
  logic [2:0]  s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // reg_select, read_not_write, nibble, drive_data,
                               // sample_busy, wait_us, backlight_on, zero fill
  logic [1:0]  m_axis_tuser;   // strobe_valid, rejected
  logic        m_axis_tlast;

  char_lcd_4bit_interface_top dut (.*);

  always #1 clk_i = ~clk_i;

  // model state and register copies
  logic       lcd_waiting, lcd_is_data, init_run, bl_lvl;
  logic [7:0] lcd_byte;
  int         init_idx;
  logic [7:0] skip_instr, skip_data;
  logic [1:0] line_sel;

  lcd_res_t   due_strobes[$];
  dir_row_t   dir_q[$];
  int         err_cnt, n_out, n_inits, n_settings, n_in_acc, cyc_cnt, rx_stall;
  bit         quiet, hold_done;
  lcd_res_t   got_r, want_r;

  function automatic void emit(input logic rs, input logic rnw, input logic [3:0] nib,
                               input logic drv, input logic sb, input logic [15:0] wt,
                               input logic strobe, input logic rej);
    lcd_res_t r;
    r = '{rs: rs, rnw: rnw, nib: nib, drv: drv, sb: sb, wait_us: wt, bl: bl_lvl,
          strobe: strobe, rej: rej, last: 1'b0};
    due_strobes.push_back(r);
  endfunction

  function automatic void start_poll();
    emit(1'b0, 1'b1, 4'h0, 1'b0, 1'b1, 16'd0, 1'b1, 1'b0);
    emit(1'b0, 1'b1, 4'h0, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0);
  endfunction

  function automatic bit init_code(input int step, output logic [7:0] b);
    init_code = 1'b1;
    b = 8'h00;
    case (step)
      0: b = 8'h29;
      1: begin
        if (line_sel == LM_TWO_LINES) b = 8'h1C;
        else if (line_sel == LM_THREE_LINES) b = 8'h1D;
        else init_code = 1'b0;
      end
      2: b = 8'h50;
      3: b = 8'h6C;
      4: b = 8'h7C;
      5: b = 8'h0C;
      6: b = 8'h01;
      7: b = 8'h06;
      default: init_code = 1'b0;
    endcase
  endfunction

  // next instruction of the init list that is not left out or skipped
  function automatic void init_next();
    logic [7:0] b;
    while (init_idx < INIT_COUNT) begin
      if (init_code(init_idx, b) && b != skip_instr) begin
        lcd_byte    = b;
        lcd_is_data = 1'b0;
        lcd_waiting = 1'b1;
        start_poll();
        return;
      end
      init_idx++;
    end
    init_run = 1'b0;
    init_idx = 0;
  endfunction

  function automatic void lcd_predict(input logic [2:0] c, input logic [7:0] v,
                                      input logic b);
    int       n0;
    lcd_res_t r;
    n0 = due_strobes.size();
    if (c > CMD_STATUS || (c != CMD_STATUS && lcd_waiting) ||
        (c == CMD_STATUS && !lcd_waiting)) begin
      emit(1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1);
    end else begin
      case (c)
        CMD_WR_INSTR, CMD_WR_DATA: begin
          if (v != ((c == CMD_WR_DATA) ? skip_data : skip_instr)) begin
            lcd_byte    = v;
            lcd_is_data = (c == CMD_WR_DATA);
            lcd_waiting = 1'b1;
            start_poll();
          end
        end
        CMD_BACKLIGHT: bl_lvl = (v != 8'h00);
        CMD_INIT: begin
          emit(1'b0, 1'b0, 4'h3, 1'b1, 1'b0, INIT_POWERUP_US, 1'b1, 1'b0);
          emit(1'b0, 1'b0, 4'h3, 1'b1, 1'b0, INIT_MID_US, 1'b1, 1'b0);
          emit(1'b0, 1'b0, 4'h3, 1'b1, 1'b0, INIT_SHORT_US, 1'b1, 1'b0);
          emit(1'b0, 1'b0, 4'h2, 1'b1, 1'b0, INIT_SHORT_US, 1'b1, 1'b0);
          init_run = 1'b1;
          init_idx = 0;
          n_inits++;
          init_next();
        end
        default: begin
          if (b) begin
            start_poll();
          end else begin
            emit(lcd_is_data, 1'b0, lcd_byte[7:4], 1'b1, 1'b0, 16'd0, 1'b1, 1'b0);
            emit(lcd_is_data, 1'b0, lcd_byte[3:0], 1'b1, 1'b0, 16'd0, 1'b1, 1'b0);
            lcd_waiting = 1'b0;
            if (init_run) begin
              init_idx++;
              init_next();
            end
          end
        end
      endcase
    end
    if (due_strobes.size() == n0) emit(1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0);
    r = due_strobes.pop_back();
    r.last = 1'b1;
    due_strobes.push_back(r);
  endfunction

  function automatic string fmt_res(input lcd_res_t r);
    return $sformatf("rs=%0d rw=%0d nib=%h drv=%0d sb=%0d wait=%0d bl=%0d strb=%0d rej=%0d last=%0d",
                     r.rs, r.rnw, r.nib, r.drv, r.sb, r.wait_us, r.bl, r.strobe, r.rej, r.last);
  endfunction

  function automatic dir_row_t drow(input logic [2:0] c, input logic [7:0] v, input logic b,
                                    input logic typed, input logic rej, input logic bl);
    dir_row_t d;
    d.cmd      = c;
    d.value    = v;
    d.busy     = b;
    d.typed    = typed;
    d.want     = '0;
    d.want.rej  = rej;
    d.want.bl   = bl;
    d.want.last = 1'b1;
    return d;
  endfunction

  // offer one item, hold it until taken, then predict what it causes
  task automatic send_req(input logic [2:0] c, input logic [7:0] v, input logic b,
                          input logic typed, input lcd_res_t want);
    int       n0;
    lcd_res_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {7'b0, b, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n0 = due_strobes.size();
    lcd_predict(c, v, b);
    if (typed) begin
      while (due_strobes.size() > n0) r = due_strobes.pop_back();
      due_strobes.push_back(want);
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] skip);
    return ($urandom_range(0, 5) == 0) ? skip : 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed write/poll/init traffic, with some noise mixed in
  task automatic random_item();
    int r;
    if (lcd_waiting) begin
      r = $urandom_range(0, 9);
      if (r < 8)
        send_req(CMD_STATUS, 8'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
      else if (r == 8)
        send_req(3'($urandom_range(CMD_WR_INSTR, CMD_INIT)), 8'($urandom), 1'($urandom),
                 1'b0, '0);
      else
        send_req(3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST)), 8'($urandom),
                 1'($urandom), 1'b0, '0);
    end else begin
      r = $urandom_range(0, 19);
      if (r < 8)
        send_req(CMD_WR_INSTR, pick_byte(skip_instr), 1'($urandom), 1'b0, '0);
      else if (r < 14)
        send_req(CMD_WR_DATA, pick_byte(skip_data), 1'($urandom), 1'b0, '0);
      else if (r < 16)
        send_req(CMD_BACKLIGHT, ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom),
                 1'($urandom), 1'b0, '0);
      else if (r < 18)
        send_req(CMD_INIT, 8'($urandom), 1'($urandom), 1'b0, '0);
      else if (r == 18)
        send_req(CMD_STATUS, 8'($urandom), 1'($urandom), 1'b0, '0);
      else
        send_req(3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST)), 8'($urandom),
                 1'($urandom), 1'b0, '0);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_INSTR_SKIP: skip_instr = data;
      CFG_DATA_SKIP:  skip_data  = data;
      default:        line_sel   = data[1:0];
    endcase
  endtask

  // wait for every pending result, then leave some idle slack
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_strobes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- result side
  always @(posedge clk_i) begin
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else if (!hold_done && n_in_acc >= HOLD_AT) begin
      // long stall: queue fills and the request side backs up
      hold_done = 1'b1;
      rx_stall  = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rx_stall = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) n_in_acc <= n_in_acc + 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = '{rs: m_axis_tdata[0], rnw: m_axis_tdata[1], nib: m_axis_tdata[5:2],
                drv: m_axis_tdata[6], sb: m_axis_tdata[7], wait_us: m_axis_tdata[23:8],
                bl: m_axis_tdata[24], strobe: m_axis_tuser[0], rej: m_axis_tuser[1],
                last: m_axis_tlast};
      n_out++;
      if (due_strobes.size() == 0) begin
        err_cnt++;
        $display("%0t: result item with nothing expected: %s", $time, fmt_res(got_r));
      end else begin
        want_r = due_strobes.pop_front();
        if (got_r !== want_r) begin
          err_cnt++;
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                   fmt_res(want_r), fmt_res(got_r));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc_cnt,
               due_strobes.size());
      $display("char_lcd_4bit_interface_top_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stim
    logic [7:0] si, sd;
    logic [1:0] lm;
    dir_row_t   d;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_INSTR_SKIP;
    cfg_wdata_i   <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 16'h0000;
    s_axis_tuser  <= CMD_WR_INSTR;
    m_axis_tready <= 1'b0;
    err_cnt = 0; n_out = 0; n_inits = 0; n_settings = 1; n_in_acc = 0; cyc_cnt = 0;
    rx_stall = 0; quiet = 1'b0; hold_done = 1'b0;
    skip_instr = 8'hFF; skip_data = 8'hFF; line_sel = LM_TWO_LINES;
    lcd_waiting = 1'b0; lcd_is_data = 1'b0; lcd_byte = 8'h00;
    init_run = 1'b0; init_idx = 0; bl_lvl = 1'b0;

    // directed table; typed rows carry their single status-only result
    dir_q.push_back(drow(CMD_STATUS,      8'h00, 1'b0, 1'b1, 1'b1, 1'b0)); // nothing pending
    dir_q.push_back(drow(CMD_UNDEF_FIRST, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0));
    dir_q.push_back(drow(CMD_UNDEF_LAST,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    dir_q.push_back(drow(CMD_BACKLIGHT,   8'h80, 1'b0, 1'b1, 1'b0, 1'b1));
    dir_q.push_back(drow(CMD_WR_INSTR,    8'hFF, 1'b0, 1'b1, 1'b0, 1'b1)); // skip code
    dir_q.push_back(drow(CMD_WR_DATA,     8'hFF, 1'b1, 1'b1, 1'b0, 1'b1)); // skip code
    dir_q.push_back(drow(CMD_WR_INSTR,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_q.push_back(drow(CMD_WR_DATA,     8'h55, 1'b0, 1'b1, 1'b1, 1'b1)); // while pending
    dir_q.push_back(drow(CMD_BACKLIGHT,   8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
    dir_q.push_back(drow(CMD_INIT,        8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
    dir_q.push_back(drow(CMD_STATUS,      8'h00, 1'b1, 1'b0, 1'b0, 1'b0)); // still busy
    dir_q.push_back(drow(CMD_STATUS,      8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_q.push_back(drow(CMD_WR_DATA,     8'hA5, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_q.push_back(drow(CMD_STATUS,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_q.push_back(drow(CMD_BACKLIGHT,   8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    dir_q.push_back(drow(CMD_INIT,        8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    dir_q.push_back(drow(CMD_STATUS,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    dir_q.push_back(drow(CMD_STATUS,      8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    for (int i = 0; i < 7; i++)
      dir_q.push_back(drow(CMD_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) begin
      d = dir_q[i];
      send_req(d.cmd, d.value, d.busy, d.typed, d.want);
    end

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: begin si = 8'h00; sd = 8'h00; lm = 2'd0; end
        1: begin si = 8'h01; sd = 8'hA5; lm = LM_THREE_LINES; end
        2: begin si = 8'h1D; sd = 8'h7F; lm = 2'd3; end
        3: begin si = 8'($urandom); sd = 8'($urandom); lm = 2'($urandom); end
        default: begin si = 8'hFF; sd = 8'hFF; lm = LM_TWO_LINES; end
      endcase
      write_reg(CFG_INSTR_SKIP, si);
      write_reg(CFG_DATA_SKIP, sd);
      write_reg(CFG_LINE_MODE, {6'b0, lm});
      cfg_we_i <= 1'b0;
      n_settings++;
      if (p == 4) quiet <= 1'b1;
      for (int i = 0; i < RAND_PER_PHASE; i++) random_item();
      // close out any transfer so the next register write lands while idle
      while (lcd_waiting) send_req(CMD_STATUS, 8'($urandom), 1'b0, 1'b0, '0);
    end

    settle();
    $display("Ran %0d requests giving %0d result items, %0d init sequences,",
             n_in_acc, n_out, n_inits);
    $display("across %0d register settings with stalls on both stream sides.", n_settings);
    if (err_cnt == 0) begin
      $display("char_lcd_4bit_interface_top_test passed");
    end else begin
      $display("%0d errors", err_cnt);
      $display("char_lcd_4bit_interface_top_test failed");
    end
    $finish;
  end

endmodule
